// ----- design/kvbt_pkg.sv -----
// Shared definitions for the key/value binding table.
// Holds default sizes, field widths, command and status codes and the control bundle that steers the cells.
// No dependencies.
`default_nettype none

package kvbt_pkg;

    // Default sizes of the table and of its fields.
    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned KEY_BITS_DEF   = 32;
    localparam int unsigned VALUE_BITS_DEF = 32;

    // Widths of the item and result fields on the ports.
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;

    // Command codes carried by an item.
    localparam logic [CMD_W-1:0] CMD_BIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNBIND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    // Status codes returned with each result.
    localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ADDED = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Actions broadcast to every cell of the chain.
    typedef struct packed {
        logic look;     // compare the stored key with the broadcast key
        logic set_val;  // overwrite the value of the matching cell
        logic append;   // write key and value into the first free cell
        logic shift;    // close the gap left by a removed entry
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- design/key_value_binding_table_top.sv -----
// Top level of the key/value binding table: item registers, sequencer,
// chain of entry cells and the result register.
// Depends on kvbt_pkg and kvbt_cell.
//
//  Channel   Direction  Handshake                  Fields
//  input     in         i_in_valid / o_in_stall    i_command, i_key, i_value_in
//  output    out        o_out_valid / i_out_stall  o_value_out, o_status,
//                                                  o_entry_count_out
//
// Each item passes through three steps: it is accepted, every cell compares its key
// in the next cycle, and the table is updated as the result is written.
// The update waits while the result register still holds an untaken result.
// Only one item is in the table logic at a time; o_in_stall is high meanwhile.
// Reset (synchronous, active low) empties the table by clearing the entry
// count; the cell contents are not cleared.
`default_nettype none

module key_value_binding_table_top
    import kvbt_pkg::*;
#(
    parameter int unsigned ENTRIES    = ENTRIES_DEF,
    parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [KEY_W-1:0]    i_key,
    input  wire logic [VALUE_W-1:0]  i_value_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [VALUE_W-1:0]  o_value_out,
    output logic      [STAT_W-1:0]   o_status,
    output logic      [COUNT_W-1:0]  o_entry_count_out
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_value_out, n_value_out;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [COUNT_W-1:0]    r_count_out;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic                  w_apply;
    logic                  w_hit;
    logic                  w_full;
    logic [IDX_W-1:0]      w_hit_idx;
    logic [VALUE_BITS-1:0] w_hit_value;
    t_cell_ctl             w_ctl;

    logic [KEY_BITS-1:0]   w_cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] w_cell_value [ENTRIES];
    logic [ENTRIES-1:0]    w_match;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_apply     = (r_state == S_APPLY) && w_out_free;

    // Sequencer: accept, compare, update.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Item registers; the key and value are cut to their stored widths.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd <= i_command;
            r_key <= KEY_BITS'(i_key);
            r_val <= VALUE_BITS'(i_value_in);
        end
    end

    // Keys are unique, so the match vector is one-hot or empty and plain
    // OR trees give the hit place and the hit value.
    always_comb begin
        w_hit_idx   = '0;
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_idx   = w_hit_idx | IDX_W'(i);
                w_hit_value = w_hit_value | w_cell_value[i];
            end
        end
    end

    assign w_hit  = |w_match;
    assign w_full = (r_count == CNT_W'(ENTRIES));

    // Actions for the cells.
    always_comb begin
        w_ctl         = '0;
        w_ctl.look    = (r_state == S_LOOK);
        w_ctl.set_val = w_apply && (r_cmd == CMD_BIND) && w_hit;
        w_ctl.append  = w_apply && (r_cmd == CMD_BIND) && !w_hit && !w_full;
        w_ctl.shift   = w_apply && (r_cmd == CMD_UNBIND) && w_hit;
    end

    // Chain of entry cells; on a shift, each cell at or above the hit place takes its upper neighbor's entry.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_nb_key;
        logic [VALUE_BITS-1:0] w_nb_value;

        if (g < ENTRIES - 1) begin : g_mid
            assign w_nb_key   = w_cell_key[g+1];
            assign w_nb_value = w_cell_value[g+1];
        end else begin : g_last
            assign w_nb_key   = '0;
            assign w_nb_value = '0;
        end

        kvbt_cell #(
            .CELL_IDX   (g),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_value    (r_val),
            .i_count    (r_count),
            .i_hit_idx  (w_hit_idx),
            .i_nb_key   (w_nb_key),
            .i_nb_value (w_nb_value),
            .o_key      (w_cell_key[g]),
            .o_value    (w_cell_value[g]),
            .o_match    (w_match[g])
        );
    end

    // Result fields and the new entry count.
    always_comb begin
        n_count     = r_count;
        n_value_out = '0;
        n_status    = ST_MISS;
        unique case (r_cmd)
            CMD_BIND: begin
                if (w_hit) begin
                    n_status = ST_FOUND;
                end else if (!w_full) begin
                    n_status = ST_ADDED;
                    n_count  = r_count + CNT_W'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_UNBIND: begin
                if (w_hit) begin
                    n_status = ST_FOUND;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_GET: begin
                if (w_hit) begin
                    n_status    = ST_FOUND;
                    n_value_out = VALUE_W'(w_hit_value);
                end
            end
            default: begin
                n_status = ST_MISS;
            end
        endcase
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_apply) begin
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_value_out <= n_value_out;
            r_status    <= n_status;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_value_out       = r_value_out;
    assign o_status          = r_status;
    assign o_entry_count_out = r_count_out;

    // The fill count never passes the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // Keys stay unique, so at most one cell matches when the table is updated.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(w_match))
        else $error("more than one cell matches the key");

    // An accepted item moves straight on to the compare cycle.
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_LOOK))
        else $error("accepted item did not enter the compare cycle");

    // An append grows the table by exactly one entry.
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.append |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance the entry count");

    // A result is written only when the register is free to take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_status) && $stable(r_value_out))
        else $error("held result was overwritten");

endmodule

`default_nettype wire

// ----- design/kvbt_cell.sv -----
// One entry of the key/value binding table: key, value and a match flag.
// Hands its contents to the cell below it when an entry is removed.
// Depends on kvbt_pkg.
`default_nettype none

module kvbt_cell
    import kvbt_pkg::*;
#(
    parameter int unsigned CELL_IDX   = 0,
    parameter int unsigned IDX_W      = 4,
    parameter int unsigned CNT_W      = 5,
    parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
    parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire logic [IDX_W-1:0]      i_hit_idx,
    input  wire logic [KEY_BITS-1:0]   i_nb_key,
    input  wire logic [VALUE_BITS-1:0] i_nb_value,
    output logic      [KEY_BITS-1:0]   o_key,
    output logic      [VALUE_BITS-1:0] o_value,
    output logic                       o_match
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_match;
    logic                  w_in_use;
    logic                  w_at_or_above_hit;
    logic                  w_is_next_free;

    // The cell holds a live entry when its place lies below the fill count.
    assign w_in_use          = (CNT_W'(CELL_IDX) < i_count);
    assign w_at_or_above_hit = (IDX_W'(CELL_IDX) >= i_hit_idx);
    assign w_is_next_free    = (CNT_W'(CELL_IDX) == i_count);

    // Match flag, taken in the compare cycle and used in the update cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.look) begin
            r_match <= w_in_use && (r_key == i_key);
        end
    end

    // Entry contents: shift from the neighbor, append, or overwrite the value.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && w_at_or_above_hit) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end else if (i_ctl.append && w_is_next_free) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.set_val && r_match) begin
            r_value <= i_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

`default_nettype wire
